@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the distance accumulator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define VDA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vda assertion failed");

// Property checked at every rising edge, reset included.
`define VDA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vda assertion failed");

`endif

@@ hw/rtl/vda_pkg.sv @@
// ----------------------------------------------------------------------------
// vda_pkg
// Types and constants shared by the vector distance accumulator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vda_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 48;
  localparam int OUT_BITS        = 48;

  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    REG_DISTANCE_MODE = 1'b0,
    REG_UNUSED        = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_EUCLIDEAN = 1'b0,
    MODE_MANHATTAN = 1'b1
  } dist_mode_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic accum;
    logic sqrt_step;
    logic load_out;
  } vda_cmd_t;

  typedef struct packed {
    dist_mode_t mode;
    logic       last;
    logic       sqrt_done;
  } vda_sts_t;

endpackage

@@ hw/rtl/vda_in_if.sv @@
// ----------------------------------------------------------------------------
// vda_in_if
// Input channel carrying one element pair and the end-of-vector flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vda_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] p_elem;
  logic signed [SAMPLE_BITS-1:0] q_elem;
  logic                          last;

  modport source (output valid, output p_elem, output q_elem, output last, input ready);
  modport sink   (input valid, input p_elem, input q_elem, input last, output ready);
endinterface

@@ hw/rtl/vda_out_if.sv @@
// ----------------------------------------------------------------------------
// vda_out_if
// Result channel carrying one distance word per vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vda_out_if;
  import vda_pkg::*;

  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] distance;
  logic                saturated;

  modport source (output valid, output distance, output saturated, input ready);
  modport sink   (input valid, input distance, input saturated, output ready);
endinterface

@@ hw/rtl/vda_ctrl.sv @@
// ----------------------------------------------------------------------------
// vda_ctrl
// Sequencer for capture, square, accumulate, square root and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  vda_pkg::vda_sts_t sts,
  output vda_pkg::vda_cmd_t cmd
);
  import vda_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state_r == ST_IDLE) && in_valid;
    cmd.square    = (state_r == ST_SQUARE);
    cmd.accum     = (state_r == ST_ACCUM);
    cmd.sqrt_step = (state_r == ST_ROOT);
    cmd.load_out  = (state_r == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          state_r <= ST_ACCUM;
        end
        ST_ACCUM: begin
          if (!sts.last) begin
            state_r <= ST_IDLE;
          end else if (sts.mode == MODE_EUCLIDEAN) begin
            state_r <= ST_ROOT;
          end else begin
            state_r <= ST_FINISH;
          end
        end
        ST_ROOT: begin
          if (sts.sqrt_done) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/vda_dp.sv @@
// ----------------------------------------------------------------------------
// vda_dp
// Difference, square, saturating accumulator, bit-serial square root and
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vda_dp #(
  parameter int SAMPLE_BITS = vda_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = vda_pkg::ACC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vda_pkg::vda_cmd_t              cmd,
  output vda_pkg::vda_sts_t              sts,
  input  vda_pkg::dist_mode_t            mode,
  input  logic signed [SAMPLE_BITS-1:0]  p_elem,
  input  logic signed [SAMPLE_BITS-1:0]  q_elem,
  input  logic                           last,
  output logic [vda_pkg::OUT_BITS-1:0]   distance,
  output logic                           saturated
);
  import vda_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int MAG_W  = SAMPLE_BITS + 1;
  localparam int TERM_W = 2 * MAG_W;
  localparam int SUM_W  = ((TERM_W > ACC_BITS) ? TERM_W : ACC_BITS) + 1;
  localparam int HALF   = (ACC_BITS + 1) / 2;
  localparam int ROOT_W = 2 * HALF;
  localparam int WIDE_W = (ROOT_W > OUT_BITS) ? ROOT_W : OUT_BITS;

  logic signed [DIFF_W-1:0] diff;
  logic        [MAG_W-1:0]  mag;
  logic        [TERM_W-1:0] sq;
  logic        [SUM_W-1:0]  sum;
  logic                     acc_ovf;
  logic        [ACC_BITS-1:0] new_acc;
  logic                     new_sat;
  logic        [ROOT_W-1:0] trial;
  logic        [ROOT_W-1:0] final_val;
  logic        [WIDE_W-1:0] wide_val;
  logic                     clamp;

  logic [MAG_W-1:0]    mag_r;
  dist_mode_t          mode_r;
  logic                last_r;
  logic [TERM_W-1:0]   term_r;
  logic [ACC_BITS-1:0] acc_r;
  logic                ovf_r;
  logic                fin_sat_r;
  logic [ROOT_W-1:0]   x_r;
  logic [ROOT_W-1:0]   res_r;
  logic [ROOT_W-1:0]   bit_r;
  logic [OUT_BITS-1:0] distance_r;
  logic                saturated_r;

  assign diff = DIFF_W'(q_elem) - DIFF_W'(p_elem);
  assign mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign sq   = mag_r * mag_r;

  assign sum     = SUM_W'(acc_r) + SUM_W'(term_r);
  assign acc_ovf = |sum[SUM_W-1:ACC_BITS];
  assign new_acc = acc_ovf ? '1 : sum[ACC_BITS-1:0];
  assign new_sat = ovf_r | acc_ovf;

  assign trial = res_r + bit_r;

  assign final_val = (mode_r == MODE_EUCLIDEAN) ? res_r : x_r;
  assign wide_val  = WIDE_W'(final_val);
  assign clamp     = wide_val > WIDE_W'(OUT_MAX);

  assign sts.mode      = mode_r;
  assign sts.last      = last_r;
  assign sts.sqrt_done = bit_r[0];

  assign distance  = distance_r;
  assign saturated = saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.accum) begin
      if (last_r) begin
        acc_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        acc_r <= new_acc;
        ovf_r <= new_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag_r  <= mag;
      mode_r <= mode;
      last_r <= last;
    end
    if (cmd.square) begin
      term_r <= (mode_r == MODE_EUCLIDEAN) ? sq : TERM_W'(mag_r);
    end
    if (cmd.accum && last_r) begin
      x_r       <= ROOT_W'(new_acc);
      res_r     <= '0;
      bit_r     <= {2'b01, {(ROOT_W-2){1'b0}}};
      fin_sat_r <= new_sat;
    end
    if (cmd.sqrt_step) begin
      if (x_r >= trial) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.load_out) begin
      distance_r  <= clamp ? OUT_MAX : wide_val[OUT_BITS-1:0];
      saturated_r <= fin_sat_r | clamp;
    end
  end

endmodule

@@ hw/rtl/vector_distance_accumulator.sv @@
// ----------------------------------------------------------------------------
// vector_distance_accumulator
// Euclidean or Manhattan distance over a stream of Q8.8 element pairs.
// ----------------------------------------------------------------------------
// Element pairs arrive on in_if, one word per element, and last marks the
// final pair of a vector. One result word per vector leaves on out_if.
// The cfg_ APB port holds the distance_mode register at byte address 0.
// Each word passes through capture, square and accumulate in turn.
// A word that does not end a vector lets the next word in once its
// accumulate step is done. A last word also loads the result
// register, after the square root in Euclidean mode, before the next
// word is accepted. On the last word, a Manhattan result goes straight
// to the result load, and a Euclidean result first passes through the
// bit-serial square root, which retires one root bit per cycle.
// The default ACC_BITS is 48.
// Reset clears the running sum, the overflow flag, the mode register
// and the result valid flag.
// A finished result sits in the output register while the receiver
// stalls; the block still takes new words, but the next result waits,
// and holds off new words, until the previous one has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_distance_accumulator #(
  parameter int SAMPLE_BITS = vda_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = vda_pkg::ACC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  vda_in_if.sink                            in_if,
  vda_out_if.source                         out_if,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [vda_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [vda_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [vda_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import vda_pkg::*;

  dist_mode_t mode_r;
  reg_idx_t   reg_idx;
  vda_cmd_t   cmd;
  vda_sts_t   sts;

  assign reg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (reg_idx == REG_DISTANCE_MODE) ?
                      CFG_DATA_W'(mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EUCLIDEAN;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (reg_idx == REG_DISTANCE_MODE)) begin
      mode_r <= dist_mode_t'(cfg_pwdata[0]);
    end
  end

  vda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vda_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .mode      (mode_r),
    .p_elem    (in_if.p_elem),
    .q_elem    (in_if.q_elem),
    .last      (in_if.last),
    .distance  (out_if.distance),
    .saturated (out_if.saturated)
  );

endmodule

@@ hw/rtl/vda_checker.sv @@
// ----------------------------------------------------------------------------
// vda_checker
// Port-level assertions for the vector distance accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vda_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [vda_pkg::OUT_BITS-1:0] distance,
  input logic                         saturated
);

  `VDA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `VDA_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(distance) && $stable(saturated))
  `VDA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)
  `VDA_ASSERT(a_one_word, clk, rst_n, in_valid && in_ready |=> !in_ready)

endmodule

bind vector_distance_accumulator vda_checker u_vda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .distance  (out_if.distance),
  .saturated (out_if.saturated)
);
